/* src/nks_pkg.sv */
// ----------------------------------------------------------------------------
// nks_pkg
// Shared types, constants and helper functions for the newest-entries
// name selector.
// ----------------------------------------------------------------------------
`default_nettype none

package nks_pkg;

  localparam int NAME_BYTES  = 24;
  localparam int NAME_W      = 8 * NAME_BYTES;
  localparam int STAMP_W     = 32;
  localparam int RANK_W      = 6;
  localparam int KEY_W       = STAMP_W + NAME_W;
  localparam int ENTRIES_DEF = 32;

  localparam logic OP_OFFER  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] name_bytes_0_7;
    logic [63:0] name_bytes_8_15;
    logic [63:0] name_bytes_16_23;
    logic [31:0] stamp;
  } req_t;

  typedef struct packed {
    logic [63:0]       out_bytes_0_7;
    logic [63:0]       out_bytes_8_15;
    logic [63:0]       out_bytes_16_23;
    logic [31:0]       out_stamp;
    logic [RANK_W-1:0] rank;
    logic              is_last;
    logic              empty_res;
  } rsp_t;

  // One table entry as kept in the memory.
  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // Clear every byte from the first zero byte on; byte 0 is in the top bits.
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] r;
    logic              ended;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (n[NAME_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
      r[NAME_W-1-8*i -: 8] = ended ? 8'h00 : n[NAME_W-1-8*i -: 8];
    end
    return r;
  endfunction

  // Fold A..Z to a..z in every byte.
  function automatic logic [NAME_W-1:0] fold_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] r;
    logic [7:0]        c;
    for (int i = 0; i < NAME_BYTES; i++) begin
      c = n[8*i +: 8];
      r[8*i +: 8] = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/nks_ctrl.sv */
// ----------------------------------------------------------------------------
// nks_ctrl
// Sequencer for offer scans, sort passes and result emission. Owns the
// fill count, the scan address and the rank counter.
// ----------------------------------------------------------------------------
`default_nettype none

module nks_ctrl
  import nks_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire logic             opcode,
  input  wire logic             match,
  input  wire logic             newer,
  input  wire logic             out_free,
  output logic                  load_in,
  output logic                  clr_acc,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  output logic                  wr_en,
  output logic                  wr_use_min,
  output logic [IDX_W-1:0]      wr_addr,
  output logic                  emit,
  output logic                  emit_empty,
  output logic [RANK_W-1:0]     rank_out,
  output logic                  is_last
);

  state_t           state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [IDX_W-1:0] addr, addr_next;
  logic [IDX_W-1:0] rank, rank_next;
  logic             sorting, sorting_next;
  logic             scan_last;
  logic             rank_last;

  assign scan_last = (CNT_W'(addr) + CNT_W'(1)) == fill;
  assign rank_last = (CNT_W'(rank) + CNT_W'(1)) == fill;
  assign rd_addr   = addr;
  assign wr_addr   = fill[IDX_W-1:0];
  assign rank_out  = RANK_W'(rank);
  assign is_last   = rank_last;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      addr    <= '0;
      rank    <= '0;
      sorting <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      addr    <= addr_next;
      rank    <= rank_next;
      sorting <= sorting_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    addr_next    = addr;
    rank_next    = rank;
    sorting_next = sorting;
    req_ready    = 1'b0;
    load_in      = 1'b0;
    clr_acc      = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_use_min   = 1'b0;
    emit         = 1'b0;
    emit_empty   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          load_in   = 1'b1;
          clr_acc   = 1'b1;
          addr_next = '0;
          rank_next = '0;
          if (opcode == OP_FINISH) begin
            sorting_next = 1'b1;
            state_next   = (fill == '0) ? ST_EMPTY : ST_SCAN;
          end else begin
            sorting_next = 1'b0;
            state_next   = (fill == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_next = ST_DRAIN;
        end else begin
          addr_next = addr + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = sorting ? ST_EMIT : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!match) begin
          if (fill < CNT_W'(ENTRIES)) begin
            wr_en     = 1'b1;
            fill_next = fill + CNT_W'(1);
          end else if (newer) begin
            wr_en      = 1'b1;
            wr_use_min = 1'b1;
          end
        end
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (rank_last) begin
            fill_next  = '0;
            state_next = ST_IDLE;
          end else begin
            rank_next  = rank + IDX_W'(1);
            addr_next  = '0;
            clr_acc    = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          emit_empty = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The table never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst) fill <= CNT_W'(ENTRIES))
    else $error("fill count above capacity");

  // Scans only touch filled entries.
  assert property (@(posedge clk) disable iff (rst) rd_en |-> CNT_W'(addr) < fill)
    else $error("scan beyond fill count");

  // The final result of a finish run empties the table.
  assert property (@(posedge clk) disable iff (rst) (emit && is_last) |=> fill == '0)
    else $error("table not emptied after finish");

  // A write never happens during a scan read or an emit.
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !rd_en && !emit)
    else $error("write overlaps scan or emit");
`endif

endmodule

`default_nettype wire

/* src/nks_dpath.sv */
// ----------------------------------------------------------------------------
// nks_dpath
// Entry memory, offer latch, scan comparators with their accumulators and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nks_dpath
  import nks_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire req_t             req,
  input  wire logic             load_in,
  input  wire logic             clr_acc,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic             wr_use_min,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic             emit,
  input  wire logic             emit_empty,
  input  wire logic [RANK_W-1:0] rank,
  input  wire logic             is_last,
  output logic                  match,
  output logic                  newer,
  output logic                  out_free,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_t                  rsp
);

  entry_t             mem [ENTRIES];
  entry_t             rd_q;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_valid;
  entry_t             in_entry;
  logic [NAME_W-1:0]  in_fold;
  logic               min_valid;
  logic [STAMP_W-1:0] min_stamp;
  logic [IDX_W-1:0]   min_idx;
  logic               best_valid;
  entry_t             best;
  logic [KEY_W-1:0]   best_key;
  logic               prev_valid;
  logic [KEY_W-1:0]   prev_key;
  logic [NAME_W-1:0]  rd_fold;
  logic [KEY_W-1:0]   rd_key;
  logic               eligible;

  // Ordering key: larger stamp first, then smaller folded name first.
  assign rd_fold  = fold_name(rd_q.name);
  assign rd_key   = {rd_q.stamp, ~rd_fold};
  assign eligible = !prev_valid || (rd_key < prev_key);
  assign newer    = in_entry.stamp > min_stamp;
  assign out_free = !rsp_valid || rsp_ready;

  // Entry memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_use_min ? min_idx : wr_addr] <= in_entry;
    end
    rd_q   <= mem[rd_addr];
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // Latch the offered entry in canonical form.
  always_ff @(posedge clk) begin
    if (load_in) begin
      in_entry.name  <= canon_name({req.name_bytes_0_7, req.name_bytes_8_15,
                                    req.name_bytes_16_23});
      in_entry.stamp <= req.stamp;
      in_fold        <= fold_name(canon_name({req.name_bytes_0_7,
                                              req.name_bytes_8_15,
                                              req.name_bytes_16_23}));
    end
  end

  // Scan accumulators: duplicate flag, oldest entry and best remaining entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      match      <= 1'b0;
      min_valid  <= 1'b0;
      best_valid <= 1'b0;
      prev_valid <= 1'b0;
    end else begin
      if (load_in) begin
        prev_valid <= 1'b0;
      end else if (emit) begin
        prev_valid <= 1'b1;
      end
      if (clr_acc) begin
        match      <= 1'b0;
        min_valid  <= 1'b0;
        best_valid <= 1'b0;
      end else if (rd_valid) begin
        if (rd_fold == in_fold) begin
          match <= 1'b1;
        end
        if (!min_valid || rd_q.stamp < min_stamp) begin
          min_valid <= 1'b1;
        end
        if (eligible && (!best_valid || rd_key > best_key)) begin
          best_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && !clr_acc) begin
      if (!min_valid || rd_q.stamp < min_stamp) begin
        min_stamp <= rd_q.stamp;
        min_idx   <= rd_idx;
      end
      if (eligible && (!best_valid || rd_key > best_key)) begin
        best     <= rd_q;
        best_key <= rd_key;
      end
    end
    if (emit) begin
      prev_key <= best_key;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit || emit_empty) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.out_bytes_0_7   <= best.name[NAME_W-1 -: 64];
      rsp.out_bytes_8_15  <= best.name[NAME_W-65 -: 64];
      rsp.out_bytes_16_23 <= best.name[63:0];
      rsp.out_stamp       <= best.stamp;
      rsp.rank            <= rank;
      rsp.is_last         <= is_last;
      rsp.empty_res       <= 1'b0;
    end else if (emit_empty) begin
      rsp.out_bytes_0_7   <= '0;
      rsp.out_bytes_8_15  <= '0;
      rsp.out_bytes_16_23 <= '0;
      rsp.out_stamp       <= '0;
      rsp.rank            <= '0;
      rsp.is_last         <= 1'b0;
      rsp.empty_res       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/newest_k_name_selector.sv */
// ----------------------------------------------------------------------------
// newest_k_name_selector
// Keeps the newest named, time-stamped entries in a table and emits them
// newest first on a finish item.
// ----------------------------------------------------------------------------
// An offer item passes the accepting state, one memory read per stored entry
// to check for a case-insensitive duplicate and to find the oldest entry, a
// drain state for the last read to land and a decide state that may write;
// on an empty table it goes from accepting to deciding. A finish item runs
// one full pass over the n stored entries for each result, paced by the
// single read port of the entry memory and held while the receiver stalls;
// an empty table gives its one result. One item is worked on at a time, and
// input is taken only while idle.
`default_nettype none

module newest_k_name_selector
  import nks_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic              match, newer, out_free;
  logic              load_in, clr_acc, rd_en, wr_en, wr_use_min;
  logic              emit, emit_empty, is_last;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [RANK_W-1:0] rank;

  nks_ctrl #(.ENTRIES(ENTRIES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .opcode     (req.opcode),
    .match      (match),
    .newer      (newer),
    .out_free   (out_free),
    .load_in    (load_in),
    .clr_acc    (clr_acc),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_use_min (wr_use_min),
    .wr_addr    (wr_addr),
    .emit       (emit),
    .emit_empty (emit_empty),
    .rank_out   (rank),
    .is_last    (is_last)
  );

  nks_dpath #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .load_in    (load_in),
    .clr_acc    (clr_acc),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_use_min (wr_use_min),
    .wr_addr    (wr_addr),
    .emit       (emit),
    .emit_empty (emit_empty),
    .rank       (rank),
    .is_last    (is_last),
    .match      (match),
    .newer      (newer),
    .out_free   (out_free),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire
